[hw/rtl/idc_pkg.sv]
// ----------------------------------------------------------------------------
// idc_pkg
// Shared types, sizes and codes for the detection classifier
// ----------------------------------------------------------------------------
package idc_pkg;

    localparam int MAX_POSITIVES = 64;
    localparam int MAX_FUZZIES   = 64;
    localparam int COORD_BITS    = 12;

    localparam int MAX_SLOTS = (MAX_POSITIVES > MAX_FUZZIES) ? MAX_POSITIVES : MAX_FUZZIES;
    localparam int POS_IDX_W = (MAX_POSITIVES > 1) ? $clog2(MAX_POSITIVES) : 1;
    localparam int FUZ_IDX_W = (MAX_FUZZIES > 1) ? $clog2(MAX_FUZZIES) : 1;
    localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);

    localparam int DIM_W   = 13;
    localparam int EDGE_W  = ((COORD_BITS > DIM_W) ? COORD_BITS : DIM_W) + 1;
    localparam int AREA_W  = 2 * DIM_W;
    localparam int UNI_W   = AREA_W + 1;
    localparam int PROD_W  = AREA_W + UNI_W;
    localparam int THR_W   = 17;
    localparam int FRAC_W  = 16;
    localparam int TPROD_W = THR_W + UNI_W;
    localparam int SCORE_W = 32;
    localparam int ADDR_W  = 3;

    localparam logic REG_THRESHOLD = 1'b0;
    localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(32768);

    typedef enum logic [1:0] {
        FN_CLEAR    = 2'd0,
        FN_LOAD_POS = 2'd1,
        FN_LOAD_FUZ = 2'd2,
        FN_CLASSIFY = 2'd3
    } func_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DET,
        ST_FETCH,
        ST_GEO,
        ST_MUL,
        ST_UNI,
        ST_XM,
        ST_CMP,
        ST_THR,
        ST_DEC
    } state_t;

    typedef struct packed {
        func_t              func;
        logic [11:0]        rect_x;
        logic [11:0]        rect_y;
        logic [12:0]        rect_width;
        logic [12:0]        rect_height;
        logic [SCORE_W-1:0] score_bits;
    } item_t;

    typedef struct packed {
        logic [SCORE_W-1:0] score_out;
        logic               tp_flag;
    } result_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [DIM_W-1:0]      w;
        logic [DIM_W-1:0]      h;
    } rect_t;

    localparam int RECT_W = $bits(rect_t);

    typedef struct packed {
        logic det_en;
        logic geo_en;
        logic mul_en;
        logic uni_en;
        logic xm_en;
        logic cmp_en;
        logic clr;
    } iou_ctrl_t;

    typedef struct packed {
        logic              found;
        logic [AREA_W-1:0] inter;
        logic [UNI_W-1:0]  uni;
        logic [IDX_W-1:0]  slot;
    } best_t;

endpackage

[hw/rtl/idc_ram.sv]
// ----------------------------------------------------------------------------
// idc_ram
// Simple dual-port RAM, one write port, one registered read port
// ----------------------------------------------------------------------------
module idc_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 50,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

[hw/rtl/idc_iou_unit.sv]
// ----------------------------------------------------------------------------
// idc_iou_unit
// Shared overlap unit: one table entry at a time through geometry, area,
// union and cross-product steps, keeping the best match so far
// ----------------------------------------------------------------------------
module idc_iou_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  idc_pkg::iou_ctrl_t ctrl,
    input  idc_pkg::rect_t    det,
    input  idc_pkg::rect_t    entry,
    input  logic [idc_pkg::IDX_W-1:0] slot,
    output idc_pkg::best_t    best
);
    import idc_pkg::*;

    logic [AREA_W-1:0] det_area_reg;
    logic [DIM_W-1:0]  iw_reg, ih_reg, ew_reg, eh_reg;
    logic [AREA_W-1:0] inter_reg, earea_reg;
    logic [AREA_W-1:0] cur_i_reg;
    logic [UNI_W-1:0]  cur_u_reg;
    logic [PROD_W-1:0] lhs_reg, rhs_reg;
    logic              found_reg;
    logic [AREA_W-1:0] best_i_reg;
    logic [UNI_W-1:0]  best_u_reg;
    logic [IDX_W-1:0]  best_slot_reg;

    logic [EDGE_W-1:0] dx1, dx2, ex1, ex2, dy1, dy2, ey1, ey2;
    logic [EDGE_W-1:0] x1, x2, y1, y2;
    logic [DIM_W-1:0]  iw, ih;
    logic [UNI_W-1:0]  uni;

    always_comb
    begin
        dx1 = EDGE_W'(det.x);
        ex1 = EDGE_W'(entry.x);
        dy1 = EDGE_W'(det.y);
        ey1 = EDGE_W'(entry.y);
        dx2 = dx1 + EDGE_W'(det.w);
        ex2 = ex1 + EDGE_W'(entry.w);
        dy2 = dy1 + EDGE_W'(det.h);
        ey2 = ey1 + EDGE_W'(entry.h);
        x1  = (dx1 > ex1) ? dx1 : ex1;
        y1  = (dy1 > ey1) ? dy1 : ey1;
        x2  = (dx2 < ex2) ? dx2 : ex2;
        y2  = (dy2 < ey2) ? dy2 : ey2;
        // no overlap in either axis means no intersection at all
        if (x2 > x1 && y2 > y1)
        begin
            iw = DIM_W'(x2 - x1);
            ih = DIM_W'(y2 - y1);
        end
        else
        begin
            iw = '0;
            ih = '0;
        end
        uni = UNI_W'(det_area_reg) + UNI_W'(earea_reg) - UNI_W'(inter_reg);
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.det_en)
        begin
            det_area_reg <= AREA_W'(det.w) * AREA_W'(det.h);
        end
        if (ctrl.geo_en)
        begin
            iw_reg <= iw;
            ih_reg <= ih;
            ew_reg <= entry.w;
            eh_reg <= entry.h;
        end
        if (ctrl.mul_en)
        begin
            inter_reg <= AREA_W'(iw_reg) * AREA_W'(ih_reg);
            earea_reg <= AREA_W'(ew_reg) * AREA_W'(eh_reg);
        end
        if (ctrl.uni_en)
        begin
            // both areas empty: overlap taken as zero
            if (uni == '0)
            begin
                cur_i_reg <= '0;
                cur_u_reg <= UNI_W'(1);
            end
            else
            begin
                cur_i_reg <= inter_reg;
                cur_u_reg <= uni;
            end
        end
        if (ctrl.xm_en)
        begin
            lhs_reg <= PROD_W'(cur_i_reg) * PROD_W'(best_u_reg);
            rhs_reg <= PROD_W'(best_i_reg) * PROD_W'(cur_u_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found_reg     <= 1'b0;
            best_i_reg    <= '0;
            best_u_reg    <= UNI_W'(1);
            best_slot_reg <= '0;
        end
        else if (ctrl.clr)
        begin
            found_reg     <= 1'b0;
            best_i_reg    <= '0;
            best_u_reg    <= UNI_W'(1);
            best_slot_reg <= '0;
        end
        else if (ctrl.cmp_en && (!found_reg || lhs_reg > rhs_reg))
        begin
            // strict compare keeps the earliest slot on ties
            found_reg     <= 1'b1;
            best_i_reg    <= cur_i_reg;
            best_u_reg    <= cur_u_reg;
            best_slot_reg <= slot;
        end
    end

    assign best.found = found_reg;
    assign best.inter = best_i_reg;
    assign best.uni   = best_u_reg;
    assign best.slot  = best_slot_reg;

    a_uni_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.cmp_en |-> cur_u_reg != '0)
        else $error("union of zero reached the compare");

    a_inter_le_uni: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.cmp_en |-> UNI_W'(cur_i_reg) <= cur_u_reg)
        else $error("intersection above union");

    a_best_u_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        best_u_reg != '0)
        else $error("best union dropped to zero");

endmodule

[hw/rtl/iou_detection_classifier_top.sv]
// ----------------------------------------------------------------------------
// iou_detection_classifier_top
// Detection classifier: positive and ignore rectangle tables, best-overlap
// matching through one shared overlap unit under a small sequencer
// ----------------------------------------------------------------------------
// clear and load items leave busy low
// classify: every valid slot below the fill count of each table goes through the
//   shared overlap unit; removed slots are stepped past
// done pulses for one cycle the cycle after the decision, unless the detection is ignored; the receiver cannot stall
// reset empties both tables and sets the threshold to one half
module iou_detection_classifier_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  idc_pkg::item_t                item,
    output logic                          done,
    output idc_pkg::result_t              result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [idc_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import idc_pkg::*;

    state_t state_reg, state_next;
    logic   table_reg, table_next;
    logic [CNT_W-1:0] k_reg, k_next;
    logic [CNT_W-1:0] pos_count_reg, fuz_count_reg;
    logic [MAX_POSITIVES-1:0] pos_valid_reg;
    logic [MAX_FUZZIES-1:0]   fuz_valid_reg;
    logic [THR_W-1:0] thr_reg;
    rect_t det_reg;
    logic [SCORE_W-1:0] score_reg;
    best_t p_best_reg;
    logic [TPROD_W-1:0] mp_reg, mf_reg;
    logic [PROD_W-1:0]  cx_pf_reg, cx_fp_reg;
    logic    done_reg;
    result_t result_reg;

    iou_ctrl_t ctrl;
    best_t     best;
    rect_t     in_rect, entry;
    logic [RECT_W-1:0] pos_rd, fuz_rd;
    logic accept, pos_we, fuz_we, slot_valid, slot_live;
    logic pm, fm, tp, fp;
    logic cfg_wr;

    assign accept = start && !busy;
    assign busy   = (state_reg != ST_IDLE);

    assign in_rect.x = COORD_BITS'(item.rect_x);
    assign in_rect.y = COORD_BITS'(item.rect_y);
    assign in_rect.w = item.rect_width;
    assign in_rect.h = item.rect_height;

    assign pos_we = accept && item.func == FN_LOAD_POS
                    && pos_count_reg < CNT_W'(MAX_POSITIVES);
    assign fuz_we = accept && item.func == FN_LOAD_FUZ
                    && fuz_count_reg < CNT_W'(MAX_FUZZIES);

    idc_ram #(.DEPTH(MAX_POSITIVES), .WIDTH(RECT_W), .AW(POS_IDX_W)) u_pos_ram (
        .clk     (clk),
        .we      (pos_we),
        .wr_addr (pos_count_reg[POS_IDX_W-1:0]),
        .wr_data (in_rect),
        .rd_addr (k_reg[POS_IDX_W-1:0]),
        .rd_data (pos_rd)
    );

    idc_ram #(.DEPTH(MAX_FUZZIES), .WIDTH(RECT_W), .AW(FUZ_IDX_W)) u_fuz_ram (
        .clk     (clk),
        .we      (fuz_we),
        .wr_addr (fuz_count_reg[FUZ_IDX_W-1:0]),
        .wr_data (in_rect),
        .rd_addr (k_reg[FUZ_IDX_W-1:0]),
        .rd_data (fuz_rd)
    );

    assign entry = table_reg ? rect_t'(fuz_rd) : rect_t'(pos_rd);

    idc_iou_unit u_iou (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .det   (det_reg),
        .entry (entry),
        .slot  (k_reg[IDX_W-1:0]),
        .best  (best)
    );

    always_comb
    begin
        if (table_reg)
        begin
            slot_live  = k_reg < fuz_count_reg;
            slot_valid = slot_live && fuz_valid_reg[k_reg[FUZ_IDX_W-1:0]];
        end
        else
        begin
            slot_live  = k_reg < pos_count_reg;
            slot_valid = slot_live && pos_valid_reg[k_reg[POS_IDX_W-1:0]];
        end
    end

    // overlap meets threshold when i * 2^16 >= thr * u
    assign pm = (TPROD_W'({p_best_reg.inter, FRAC_W'(0)}) >= mp_reg);
    assign fm = (TPROD_W'({best.inter, FRAC_W'(0)}) >= mf_reg);
    assign fp = !pm && !fm;
    assign tp = pm && (cx_pf_reg >= cx_fp_reg);

    always_comb
    begin
        state_next = state_reg;
        table_next = table_reg;
        k_next     = k_reg;
        ctrl       = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && item.func == FN_CLASSIFY)
                begin
                    state_next = ST_DET;
                end
            end
            ST_DET:
            begin
                ctrl.det_en = 1'b1;
                ctrl.clr    = 1'b1;
                table_next  = 1'b0;
                k_next      = '0;
                state_next  = ST_FETCH;
            end
            ST_FETCH:
            begin
                if (!slot_live)
                begin
                    k_next = '0;
                    if (table_reg)
                    begin
                        state_next = ST_THR;
                    end
                    else
                    begin
                        ctrl.clr   = 1'b1;
                        table_next = 1'b1;
                    end
                end
                else if (slot_valid)
                begin
                    state_next = ST_GEO;
                end
                else
                begin
                    k_next = k_reg + CNT_W'(1);
                end
            end
            ST_GEO:
            begin
                ctrl.geo_en = 1'b1;
                state_next  = ST_MUL;
            end
            ST_MUL:
            begin
                ctrl.mul_en = 1'b1;
                state_next  = ST_UNI;
            end
            ST_UNI:
            begin
                ctrl.uni_en = 1'b1;
                state_next  = ST_XM;
            end
            ST_XM:
            begin
                ctrl.xm_en = 1'b1;
                state_next = ST_CMP;
            end
            ST_CMP:
            begin
                ctrl.cmp_en = 1'b1;
                k_next      = k_reg + CNT_W'(1);
                state_next  = ST_FETCH;
            end
            ST_THR:
            begin
                state_next = ST_DEC;
            end
            ST_DEC:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            table_reg <= 1'b0;
            k_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            table_reg <= table_next;
            k_reg     <= k_next;
        end
    end

    // table bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_count_reg <= '0;
            fuz_count_reg <= '0;
            pos_valid_reg <= '0;
            fuz_valid_reg <= '0;
        end
        else if (accept && item.func == FN_CLEAR)
        begin
            pos_count_reg <= '0;
            fuz_count_reg <= '0;
            pos_valid_reg <= '0;
            fuz_valid_reg <= '0;
        end
        else
        begin
            if (pos_we)
            begin
                pos_valid_reg[pos_count_reg[POS_IDX_W-1:0]] <= 1'b1;
                pos_count_reg <= pos_count_reg + CNT_W'(1);
            end
            if (fuz_we)
            begin
                fuz_valid_reg[fuz_count_reg[FUZ_IDX_W-1:0]] <= 1'b1;
                fuz_count_reg <= fuz_count_reg + CNT_W'(1);
            end
            if (state_reg == ST_DEC && !fp)
            begin
                if (tp)
                begin
                    if (p_best_reg.found)
                    begin
                        pos_valid_reg[POS_IDX_W'(p_best_reg.slot)] <= 1'b0;
                    end
                end
                else if (best.found)
                begin
                    fuz_valid_reg[FUZ_IDX_W'(best.slot)] <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && item.func == FN_CLASSIFY)
        begin
            det_reg   <= in_rect;
            score_reg <= item.score_bits;
        end
        if (state_reg == ST_FETCH && !slot_live && !table_reg)
        begin
            p_best_reg <= best;
        end
        if (state_reg == ST_THR)
        begin
            mp_reg    <= TPROD_W'(thr_reg) * TPROD_W'(p_best_reg.uni);
            mf_reg    <= TPROD_W'(thr_reg) * TPROD_W'(best.uni);
            cx_pf_reg <= PROD_W'(p_best_reg.inter) * PROD_W'(best.uni);
            cx_fp_reg <= PROD_W'(best.inter) * PROD_W'(p_best_reg.uni);
        end
        if (state_reg == ST_DEC)
        begin
            result_reg.score_out <= score_reg;
            result_reg.tp_flag   <= !fp;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (state_reg == ST_DEC) && (fp || tp);
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    // configuration port
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THRESHOLD_RESET;
        end
        else if (cfg_wr && paddr[ADDR_W-1] == REG_THRESHOLD)
        begin
            thr_reg <= pwdata[THR_W-1:0];
        end
    end

    assign prdata = (paddr[ADDR_W-1] == REG_THRESHOLD) ? 32'(thr_reg) : 32'd0;

    a_done_after_dec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_DEC))
        else $error("result strobe without a decision");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while still scanning");

    a_pos_count: assert property (@(posedge clk) disable iff (!rst_n)
        pos_count_reg <= CNT_W'(MAX_POSITIVES) && fuz_count_reg <= CNT_W'(MAX_FUZZIES))
        else $error("table count past capacity");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_GEO) |-> $past(slot_valid))
        else $error("overlap started on an empty slot");

endmodule
